// ===== rtl/core/cam_pkg.sv =====
package cam_pkg;

    localparam int HOLDER_W = 16;
    localparam int QTY_W    = 24;
    localparam int PRICE_W  = 24;
    localparam int STAMP_W  = 32;
    localparam int VOL_W    = 28;

    localparam logic OP_ORDER   = 1'b0;
    localparam logic OP_TICK    = 1'b1;
    localparam logic SIDE_BUY   = 1'b0;
    localparam logic SIDE_SELL  = 1'b1;
    localparam logic KIND_DEAL  = 1'b0;
    localparam logic KIND_QUOTE = 1'b1;

    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

    typedef struct packed {
        logic [HOLDER_W-1:0] holder;
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    qty;
        logic [STAMP_W-1:0]  stamp;
    } order_t;

    typedef struct packed {
        logic   op;
        logic   side;
        order_t order;
    } req_t;

    typedef struct packed {
        logic [HOLDER_W-1:0] holder;
        logic                side;
        logic [QTY_W-1:0]    qty;
    } deal_t;

    typedef struct packed {
        logic                kind;
        logic [HOLDER_W-1:0] holder;
        logic                side;
        logic [QTY_W-1:0]    filled;
        logic [PRICE_W-1:0]  price;
        logic [STAMP_W-1:0]  tick_time;
        logic [VOL_W-1:0]    volume;
        logic                overflow;
        logic                last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EQ_SELL,
        ST_TAIL_B,
        ST_TAIL_S,
        ST_RD,
        ST_LOAD,
        ST_OUT,
        ST_QUOTE,
        ST_QOUT
    } state_t;

endpackage

// ===== rtl/core/cam_ram.sv =====
module cam_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/cam_front.sv =====
module cam_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cam_pkg::req_t in_req,
    output logic          q_valid,
    input  logic          q_ready,
    output cam_pkg::req_t q_req
);
    import cam_pkg::*;

    // two-entry request queue between the port and the engine
    req_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_req    = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end
endmodule

// ===== rtl/core/cam_book.sv =====
module cam_book #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sell_book,
    input  logic                       ins,
    input  cam_pkg::order_t            ins_order,
    input  logic                       pop,
    input  logic                       clear,
    output cam_pkg::order_t            head,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       full
);
    import cam_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // kept sorted best-first; insert shifts the tail down, pop shifts up
    order_t          ent_reg [DEPTH];
    logic [CW-1:0]   count_reg, count_next;
    logic [DEPTH-1:0] ahead;

    assign head  = ent_reg[0];
    assign count = count_reg;
    assign full  = (count_reg == CW'(DEPTH));

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (count_reg <= CW'(i))
            begin
                ahead[i] = 1'b1;
            end
            else if (ins_order.price != ent_reg[i].price)
            begin
                ahead[i] = sell_book ? (ins_order.price < ent_reg[i].price)
                                     : (ins_order.price > ent_reg[i].price);
            end
            else
            begin
                // equal prices: earlier stamp first; on equal stamps a newer buy ranks ahead, a newer sell behind
                ahead[i] = sell_book ? (ins_order.stamp < ent_reg[i].stamp)
                                     : (ins_order.stamp <= ent_reg[i].stamp);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (ins && !full)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ins && !full && ahead[i])
            begin
                if (i == 0)
                begin
                    ent_reg[i] <= ins_order;
                end
                else if (!ahead[(i == 0) ? 0 : i - 1])
                begin
                    ent_reg[i] <= ins_order;
                end
                else
                begin
                    ent_reg[i] <= ent_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (pop && i < DEPTH - 1)
            begin
                ent_reg[i] <= ent_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end
endmodule

// ===== rtl/core/cam_back.sv =====
module cam_back #(
    parameter int BOOK_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  cam_pkg::req_t q_req,
    output logic          res_valid,
    input  logic          res_ready,
    output cam_pkg::res_t res
);
    import cam_pkg::*;

    localparam int CW    = $clog2(BOOK_DEPTH + 1);
    localparam int ND    = 2 * BOOK_DEPTH;
    localparam int NDW   = $clog2(ND + 1);
    localparam int AW    = $clog2(ND);
    localparam int DEALW = $bits(deal_t);

    state_t state_reg, state_next;

    order_t        bhead, shead;
    logic [CW-1:0] bcnt, scnt;
    logic          bfull, sfull;
    logic          b_ins, s_ins, b_pop, s_pop, books_clr;

    logic [QTY_W-1:0]   bfill_reg, sfill_reg;
    logic [QTY_W-1:0]   brem, srem;
    logic [VOL_W-1:0]   total_reg;
    logic [VOL_W:0]     total_sum;
    logic [PRICE_W-1:0] deal_price_reg, last_price_reg, quote_price;
    logic [STAMP_W-1:0] tick_time_reg;
    logic [NDW-1:0]     nd_reg, rd_idx_reg;
    logic               overflow_reg;
    logic               can_match;

    logic  deal_we;
    deal_t deal_wd, deal_rd;
    logic [DEALW-1:0] deal_rd_bits;

    res_t res_reg;
    logic res_valid_reg;

    cam_book #(.DEPTH(BOOK_DEPTH)) u_buy (
        .clk(clk), .rst_n(rst_n), .sell_book(SIDE_BUY), .ins(b_ins),
        .ins_order(q_req.order), .pop(b_pop), .clear(books_clr),
        .head(bhead), .count(bcnt), .full(bfull)
    );

    cam_book #(.DEPTH(BOOK_DEPTH)) u_sell (
        .clk(clk), .rst_n(rst_n), .sell_book(SIDE_SELL), .ins(s_ins),
        .ins_order(q_req.order), .pop(s_pop), .clear(books_clr),
        .head(shead), .count(scnt), .full(sfull)
    );

    cam_ram #(.WIDTH(DEALW), .DEPTH(ND)) u_deals (
        .clk(clk), .we(deal_we), .waddr(nd_reg[AW-1:0]), .wdata(deal_wd),
        .raddr(rd_idx_reg[AW-1:0]), .rdata(deal_rd_bits)
    );

    assign deal_rd   = deal_t'(deal_rd_bits);
    assign brem      = bhead.qty - bfill_reg;
    assign srem      = shead.qty - sfill_reg;
    assign can_match = (bcnt != '0) && (scnt != '0) && (bhead.price >= shead.price);
    assign quote_price = (nd_reg != '0) ? deal_price_reg : last_price_reg;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        total_sum = {1'b0, total_reg} + (VOL_W + 1)'((brem > srem) ? srem : brem);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_req.op == OP_TICK)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (!can_match)
                begin
                    state_next = ST_TAIL_B;
                end
                else if (brem == srem)
                begin
                    state_next = ST_EQ_SELL;
                end
            end
            ST_EQ_SELL: state_next = ST_MATCH;
            ST_TAIL_B:  state_next = ST_TAIL_S;
            ST_TAIL_S:
            begin
                if (nd_reg != '0 || (scnt != '0 && sfill_reg != '0))
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_QUOTE;
                end
            end
            ST_RD:   state_next = ST_LOAD;
            ST_LOAD: state_next = ST_OUT;
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = (rd_idx_reg + 1'b1 == nd_reg) ? ST_QUOTE : ST_RD;
                end
            end
            ST_QUOTE: state_next = ST_QOUT;
            ST_QOUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_ready   = 1'b0;
        b_ins     = 1'b0;
        s_ins     = 1'b0;
        b_pop     = 1'b0;
        s_pop     = 1'b0;
        books_clr = 1'b0;
        deal_we   = 1'b0;
        deal_wd   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                b_ins   = q_valid && q_req.op == OP_ORDER && q_req.side == SIDE_BUY;
                s_ins   = q_valid && q_req.op == OP_ORDER && q_req.side == SIDE_SELL;
            end
            ST_MATCH:
            begin
                if (can_match)
                begin
                    deal_we = 1'b1;
                    if (brem > srem)
                    begin
                        deal_wd = '{holder: shead.holder, side: SIDE_SELL, qty: shead.qty};
                        s_pop   = 1'b1;
                    end
                    else
                    begin
                        deal_wd = '{holder: bhead.holder, side: SIDE_BUY, qty: bhead.qty};
                        b_pop   = 1'b1;
                    end
                end
            end
            ST_EQ_SELL:
            begin
                deal_we = 1'b1;
                deal_wd = '{holder: shead.holder, side: SIDE_SELL, qty: shead.qty};
                s_pop   = 1'b1;
            end
            ST_TAIL_B:
            begin
                deal_we = (bcnt != '0) && (bfill_reg != '0);
                deal_wd = '{holder: bhead.holder, side: SIDE_BUY, qty: bfill_reg};
            end
            ST_TAIL_S:
            begin
                deal_we = (scnt != '0) && (sfill_reg != '0);
                deal_wd = '{holder: shead.holder, side: SIDE_SELL, qty: sfill_reg};
            end
            ST_QOUT:
            begin
                books_clr = res_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            overflow_reg   <= 1'b0;
            last_price_reg <= '0;
            res_valid_reg  <= 1'b0;
            nd_reg         <= '0;
            rd_idx_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((b_ins && bfull) || (s_ins && sfull))
            begin
                overflow_reg <= 1'b1;
            end
            if (state_reg == ST_IDLE && state_next == ST_MATCH)
            begin
                nd_reg     <= '0;
                rd_idx_reg <= '0;
            end
            if (deal_we)
            begin
                nd_reg <= nd_reg + 1'b1;
            end
            if (state_reg == ST_LOAD)
            begin
                res_valid_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && res_ready)
            begin
                res_valid_reg <= 1'b0;
                rd_idx_reg    <= rd_idx_reg + 1'b1;
            end
            if (state_reg == ST_QUOTE)
            begin
                res_valid_reg  <= 1'b1;
                last_price_reg <= quote_price;
            end
            if (state_reg == ST_QOUT && res_ready)
            begin
                res_valid_reg <= 1'b0;
                overflow_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                bfill_reg     <= '0;
                sfill_reg     <= '0;
                total_reg     <= '0;
                tick_time_reg <= q_req.order.stamp;
            end
            ST_MATCH:
            begin
                if (can_match)
                begin
                    total_reg <= total_sum[VOL_W] ? VOL_MAX : total_sum[VOL_W-1:0];
                    if (brem > srem)
                    begin
                        bfill_reg      <= bfill_reg + srem;
                        sfill_reg      <= '0;
                        deal_price_reg <= bhead.price;
                    end
                    else if (brem < srem)
                    begin
                        sfill_reg      <= sfill_reg + brem;
                        bfill_reg      <= '0;
                        deal_price_reg <= shead.price;
                    end
                    else
                    begin
                        bfill_reg      <= '0;
                        deal_price_reg <= bhead.price;
                    end
                end
            end
            ST_EQ_SELL:
            begin
                sfill_reg <= '0;
            end
            ST_LOAD:
            begin
                res_reg <= '{kind: KIND_DEAL, holder: deal_rd.holder, side: deal_rd.side,
                             filled: deal_rd.qty, price: deal_price_reg,
                             tick_time: tick_time_reg, volume: '0, overflow: 1'b0,
                             last: 1'b0};
            end
            ST_QUOTE:
            begin
                res_reg <= '{kind: KIND_QUOTE, holder: '0, side: 1'b0, filled: '0,
                             price: quote_price, tick_time: tick_time_reg,
                             volume: (nd_reg != '0) ? total_reg : '0,
                             overflow: overflow_reg, last: 1'b1};
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== rtl/core/call_auction_order_matcher_core.sv =====
// channel   dir  tdata (low bit up)                                    tuser  tlast
// s_axis    in   holder_id, side, quantity, limit_price, time_stamp     operation  -
// m_axis    out  deal_holder, deal_side, filled_quantity, clearing_price,
//                tick_time, total_volume, book_overflow                 kind   last_of_run
// An order passes through the two-entry queue and is filed into its sorted book
// in the cycle it leaves it. A tick leaves the queue, then the engine runs ST_MATCH per
// match step (plus ST_EQ_SELL when remainders are equal) and once more to see matching
// stop, ST_TAIL_B, ST_TAIL_S, ST_RD, ST_LOAD, ST_OUT per deal, then ST_QUOTE and ST_QOUT.
// m_axis stalls hold the engine; s_axis is taken while the queue has room.
// rst_n clears books' counts, last price, overflow flag and the queue.
module call_auction_order_matcher_core #(
    parameter int BOOK_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // holder_id, side, quantity, limit_price, time_stamp
    input  logic         s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // deal_holder, deal_side, filled_quantity,
                                        // clearing_price, tick_time, total_volume, book_overflow
    output logic         m_axis_tuser,  // kind
    output logic         m_axis_tlast   // last_of_run
);
    import cam_pkg::*;

    req_t in_req, q_req;
    res_t res;
    logic q_valid, q_ready;

    always_comb
    begin
        in_req.op           = s_axis_tuser;
        in_req.order.holder = s_axis_tdata[15:0];
        in_req.side         = s_axis_tdata[16];
        in_req.order.qty    = s_axis_tdata[40:17];
        in_req.order.price  = s_axis_tdata[64:41];
        in_req.order.stamp  = s_axis_tdata[96:65];
    end

    cam_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    cam_back #(.BOOK_DEPTH(BOOK_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {2'b00, res.overflow, res.volume, res.tick_time, res.price,
                           res.filled, res.side, res.holder};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
endmodule
